@@ hw/rtl/tcgr_pkg.sv @@
// Shared types, constants and helpers for the text cursor glyph renderer.
`default_nettype none

package tcgr_pkg;

   localparam int GLYPH_WIDTH_DEF  = 6;
   localparam int GLYPH_HEIGHT_DEF = 8;

   localparam int COORD_W  = 9;
   localparam int COLOR_W  = 16;
   localparam int BITS_W   = 48;
   localparam int CELL_W   = 3;   // column / row index inside a cell (8-pixel stride)
   localparam int POS_W    = 6;   // col*8+row

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COORD_W-1:0] RESET_SCREEN_WIDTH  = 9'd320;
   localparam logic [COORD_W-1:0] RESET_SCREEN_HEIGHT = 9'd480;

   // register select = paddr[2]
   localparam logic REG_SEL_WIDTH  = 1'b0;
   localparam logic REG_SEL_HEIGHT = 1'b1;

   // input kinds
   localparam logic KIND_SET_CURSOR = 1'b0;
   localparam logic KIND_CHAR       = 1'b1;

   // result kinds
   localparam logic [1:0] RK_STATUS = 2'd0;
   localparam logic [1:0] RK_ADDR   = 2'd1;
   localparam logic [1:0] RK_WINDOW = 2'd2;
   localparam logic [1:0] RK_STREAM = 2'd3;

   // job modes
   localparam logic [1:0] MODE_STATUS = 2'd0;
   localparam logic [1:0] MODE_TRANSP = 2'd1;
   localparam logic [1:0] MODE_OPAQUE = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic               status;
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
      logic [BITS_W-1:0]  bits;    // already trimmed to the cell
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
   } job_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COORD_W-1:0] window_x_end;
      logic [COORD_W-1:0] window_y_end;
      logic [COLOR_W-1:0] pixel_color;
      logic               status;
      logic               last;
   } res_type;

   typedef struct packed {
      logic busy;
      logic final_step;
      logic ready;
   } emit_ctrl_type;

   // Glyph bits that fall inside a cell of gw columns by gh rows.
   function automatic logic [BITS_W-1:0] cell_mask(input int gw, input int gh);
      logic [BITS_W-1:0] m;
      m = '0;
      for (int p = 0; p < BITS_W; p++) begin
         m[p] = ((p >> 3) < gw) && ((p & 7) < gh);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tcgr_csr.sv @@
// Screen size registers behind the APB-style configuration port.
`default_nettype none

module tcgr_csr
   import tcgr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [COORD_W-1:0]    screen_width,
   output logic      [COORD_W-1:0]    screen_height
);

   logic [COORD_W-1:0] width_ff, width_in;
   logic [COORD_W-1:0] height_ff, height_in;
   logic               wr_en;
   logic               sel;

   assign csr_pready = 1'b1;
   assign sel        = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en && sel == REG_SEL_WIDTH)  width_in  = csr_pwdata[COORD_W-1:0];
      if (wr_en && sel == REG_SEL_HEIGHT) height_in = csr_pwdata[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_SCREEN_WIDTH;
         height_ff <= RESET_SCREEN_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_prdata = (sel == REG_SEL_HEIGHT)
                     ? {{(CSR_DATA_W-COORD_W){1'b0}}, height_ff}
                     : {{(CSR_DATA_W-COORD_W){1'b0}}, width_ff};

   assign screen_width  = width_ff;
   assign screen_height = height_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tcgr_cursor.sv @@
// Cursor state and per-transaction decode: range checks, wrap, job setup.
`default_nettype none

module tcgr_cursor
   import tcgr_pkg::*;
#(
   parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               kind,
   input  wire logic [COORD_W-1:0] new_x,
   input  wire logic [COORD_W-1:0] new_y,
   input  wire logic               glyph_found,
   input  wire logic [BITS_W-1:0]  glyph_bits,
   input  wire logic [COLOR_W-1:0] fg_color,
   input  wire logic [COLOR_W-1:0] bg_color,
   input  wire logic [COORD_W-1:0] screen_width,
   input  wire logic [COORD_W-1:0] screen_height,
   output job_type                 job
);

   localparam logic [BITS_W-1:0] CellMask = cell_mask(GLYPH_WIDTH, GLYPH_HEIGHT);

   logic [COORD_W-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_W-1:0] cursor_y_ff, cursor_y_in;

   logic               wrap;
   logic               below;
   logic               set_bad;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W:0]   cell_y;

   assign wrap    = ({1'b0, cursor_x_ff} + (COORD_W+1)'(GLYPH_WIDTH)) > {1'b0, screen_width};
   assign cell_x  = wrap ? '0 : cursor_x_ff;
   assign cell_y  = wrap ? ({1'b0, cursor_y_ff} + (COORD_W+1)'(GLYPH_HEIGHT))
                         : {1'b0, cursor_y_ff};
   assign below   = ({1'b0, cell_y} + (COORD_W+2)'(GLYPH_HEIGHT)) > {2'b0, screen_height};
   assign set_bad = (new_x >= screen_width) || (new_y >= screen_height);

   always_comb begin
      job.mode   = MODE_STATUS;
      job.status = 1'b0;
      job.base_x = cell_x;
      job.base_y = cell_y[COORD_W-1:0];
      job.bits   = glyph_bits & CellMask;
      job.fg     = fg_color;
      job.bg     = bg_color;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (kind == KIND_SET_CURSOR) begin
         job.status = set_bad;
         if (accept && !set_bad) begin
            cursor_x_in = new_x;
            cursor_y_in = new_y;
         end
      end else if (!glyph_found || below) begin
         // missing glyph or cell below the screen: cursor untouched
         job.status = 1'b1;
      end else begin
         job.mode = (fg_color == bg_color) ? MODE_TRANSP : MODE_OPAQUE;
         if (accept) begin
            cursor_x_in = cell_x + COORD_W'(GLYPH_WIDTH);
            cursor_y_in = cell_y[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tcgr_emit.sv @@
// Result sequencer: walks one job's results (window, pixels or lit addresses, status) into the output register.
`default_nettype none

module tcgr_emit
   import tcgr_pkg::*;
#(
   parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire job_type job,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   output res_type      rsp,
   output emit_ctrl_type ctrl
);

   localparam logic [1:0] ST_WIN  = 2'd0;
   localparam logic [1:0] ST_PIX  = 2'd1;
   localparam logic [1:0] ST_LIT  = 2'd2;
   localparam logic [1:0] ST_STAT = 2'd3;

   localparam logic [CELL_W-1:0] ColLast = CELL_W'(GLYPH_WIDTH - 1);
   localparam logic [CELL_W-1:0] RowLast = CELL_W'(GLYPH_HEIGHT - 1);

   logic               busy_ff, busy_in;
   logic [1:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   job_type            job_ff, job_in;
   logic [CELL_W-1:0]  row_ff, row_in;
   logic [CELL_W-1:0]  col_ff, col_in;
   logic [BITS_W-1:0]  pend_ff, pend_in;
   res_type            rsp_ff, rsp_in;

   logic               adv;
   logic               final_step;
   logic [1:0]         load_state;
   logic [BITS_W-1:0]  low;
   logic [POS_W-1:0]   lit_pos;
   logic [2**POS_W-1:0] bits_wide;
   logic               opq_lit;
   res_type            res_now;
   logic [1:0]         state_step;
   logic [CELL_W-1:0]  row_step, col_step;
   logic [BITS_W-1:0]  pend_step;

   assign adv        = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign final_step = (state_ff == ST_STAT);

   // lowest pending lit pixel, column-major order
   assign low = pend_ff & (~pend_ff + BITS_W'(1));
   always_comb begin
      lit_pos = '0;
      for (int p = 0; p < BITS_W; p++) begin
         if (low[p]) lit_pos = lit_pos | POS_W'(p);
      end
   end

   assign bits_wide = {{(2**POS_W-BITS_W){1'b0}}, job_ff.bits};
   assign opq_lit   = bits_wide[{col_ff, row_ff}];

   always_comb begin
      res_now    = '0;
      state_step = state_ff;
      row_step   = row_ff;
      col_step   = col_ff;
      pend_step  = pend_ff;
      case (state_ff)
         ST_WIN: begin
            res_now.kind         = RK_WINDOW;
            res_now.pixel_x      = job_ff.base_x;
            res_now.pixel_y      = job_ff.base_y;
            res_now.window_x_end = job_ff.base_x + COORD_W'(GLYPH_WIDTH - 1);
            res_now.window_y_end = job_ff.base_y + COORD_W'(GLYPH_HEIGHT - 1);
            state_step = ST_PIX;
            row_step   = '0;
            col_step   = '0;
         end
         ST_PIX: begin
            res_now.kind        = RK_STREAM;
            res_now.pixel_x     = job_ff.base_x + COORD_W'(col_ff);
            res_now.pixel_y     = job_ff.base_y + COORD_W'(row_ff);
            res_now.pixel_color = opq_lit ? job_ff.fg : job_ff.bg;
            if (col_ff == ColLast) begin
               col_step = '0;
               if (row_ff == RowLast) state_step = ST_STAT;
               else row_step = row_ff + CELL_W'(1);
            end else begin
               col_step = col_ff + CELL_W'(1);
            end
         end
         ST_LIT: begin
            res_now.kind        = RK_ADDR;
            res_now.pixel_x     = job_ff.base_x + COORD_W'(lit_pos[POS_W-1:3]);
            res_now.pixel_y     = job_ff.base_y + COORD_W'(lit_pos[2:0]);
            res_now.pixel_color = job_ff.fg;
            pend_step = pend_ff & ~low;
            if (pend_step == '0) state_step = ST_STAT;
         end
         ST_STAT: begin
            res_now.kind   = RK_STATUS;
            res_now.status = job_ff.status;
            res_now.last   = 1'b1;
         end
         default: begin
            state_step = ST_STAT;
         end
      endcase
   end

   always_comb begin
      if (job.mode == MODE_OPAQUE)                      load_state = ST_WIN;
      else if (job.mode == MODE_TRANSP && job.bits != '0) load_state = ST_LIT;
      else                                              load_state = ST_STAT;
   end

   always_comb begin
      busy_in  = busy_ff;
      state_in = state_ff;
      job_in   = job_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      pend_in  = pend_ff;
      if (load) begin
         busy_in  = 1'b1;
         state_in = load_state;
         job_in   = job;
         row_in   = '0;
         col_in   = '0;
         pend_in  = job.bits;
      end else if (adv) begin
         busy_in  = !final_step;
         state_in = state_step;
         row_in   = row_step;
         col_in   = col_step;
         pend_in  = pend_step;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_in       = res_now;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         state_ff     <= ST_STAT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;
   assign ctrl.busy       = busy_ff;
   assign ctrl.final_step = busy_ff && final_step;
   assign ctrl.ready      = !busy_ff || (adv && final_step);

endmodule

`default_nettype wire

@@ hw/rtl/text_cursor_glyph_renderer.sv @@
// Top level: text cursor and 6x8 glyph renderer with stream ports and APB registers.
// After accept, the job is registered in the sequencer and its first result then goes into the output register.
// Throughput: one result per cycle from the output register unless rsp_tready stalls it; an item
//   gives 1 result for set-cursor or rejected, lit+1 transparent, 50 opaque (6x8 cell).
// The next request is taken in the cycle its predecessor's status result is loaded out.
// Reset (synchronous): cursor to 0,0, screen 320x480, no job pending, output empty.
`default_nettype none

module text_cursor_glyph_renderer
   import tcgr_pkg::*;
#(
   parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
   parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [8:0] new_x, [17:9] new_y, [18] glyph_found, [66:19] glyph_bits,
   // [82:67] fg_color, [98:83] bg_color, [103:99] zero
   input  wire logic [103:0]          req_tdata,
   // [0] kind
   input  wire logic [0:0]            req_tuser,
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [8:0] pixel_x, [17:9] pixel_y, [26:18] window_x_end, [35:27] window_y_end,
   // [51:36] pixel_color, [52] status, [55:53] zero
   output logic [55:0]                rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [COORD_W-1:0] screen_width;
   logic [COORD_W-1:0] screen_height;
   logic               req_accept;
   job_type            job;
   res_type            rsp;
   emit_ctrl_type      ctrl;

   tcgr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .screen_width  (screen_width),
      .screen_height (screen_height)
   );

   // ready comes from the sequencer: free, or loading its final status this cycle
   assign req_tready = ctrl.ready;
   assign req_accept = req_tvalid && req_tready;

   // decode runs on the raw request; the cursor commits on accept so the
   // following transaction already sees the advanced position
   tcgr_cursor #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .kind          (req_tuser[0]),
      .new_x         (req_tdata[8:0]),
      .new_y         (req_tdata[17:9]),
      .glyph_found   (req_tdata[18]),
      .glyph_bits    (req_tdata[66:19]),
      .fg_color      (req_tdata[82:67]),
      .bg_color      (req_tdata[98:83]),
      .screen_width  (screen_width),
      .screen_height (screen_height),
      .job           (job)
   );

   tcgr_emit #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .job       (job),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .ctrl      (ctrl)
   );

   assign rsp_tdata = {3'b000, rsp.status, rsp.pixel_color, rsp.window_y_end,
                       rsp.window_x_end, rsp.pixel_y, rsp.pixel_x};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

   // the status result, and only it, closes a transaction
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == RK_STATUS)))
      else $error("tlast does not match status result");

   // a new request may only overlap the final status step of the current job
   a_overlap_on_final: assert property (@(posedge clock) disable iff (reset)
      (req_accept && ctrl.busy) |-> ctrl.final_step)
      else $error("request accepted while job still emitting pixels");

   // window edges follow the cell origin
   a_window_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == RK_WINDOW) |->
         (rsp.window_x_end == rsp.pixel_x + COORD_W'(GLYPH_WIDTH - 1)) &&
         (rsp.window_y_end == rsp.pixel_y + COORD_W'(GLYPH_HEIGHT - 1)))
      else $error("window edges inconsistent with origin");

endmodule

`default_nettype wire
